// ===== rtl/pcc_pkg.sv =====
// package for the press cycle controller: payload types, phase codes, reset values
package pcc_pkg;

  localparam int DIP_W    = 8;
  localparam int DWELL_W  = 12;
  localparam int CNT_W    = 8;
  localparam int TICK_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_EXTEND  = 2'd1;
  localparam logic [1:0] PH_DWELL   = 2'd2;
  localparam logic [1:0] PH_RETRACT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TENTH_TICKS   = 2'd3;

  localparam logic [CNT_W-1:0]  PRESS_TICKS_RST   = 8'd20;
  localparam logic [CNT_W-1:0]  RELEASE_TICKS_RST = 8'd20;
  localparam logic [TICK_W-1:0] PULSE_TICKS_RST   = 16'd1000;
  localparam logic [TICK_W-1:0] TENTH_TICKS_RST   = 16'd100;

  typedef struct packed {
    logic             up_raw;
    logic             down_raw;
    logic [DIP_W-1:0] dip_setting;
  } pcc_in_t;

  typedef struct packed {
    logic       extend_drive;
    logic       retract_drive;
    logic       up_stable;
    logic       down_stable;
    logic [1:0] phase;
  } pcc_out_t;

endpackage

// ===== rtl/press_cycle_controller.sv =====
// press cycle controller: switch debouncers and timed extend/dwell/retract sequencer
//
// each input transaction is one sample tick carrying the raw up and down switch
// levels and the dip dwell setting. every accepted transaction gives exactly one
// result transaction with the solenoid drives, debounced levels and the phase
// that was active during that tick.
// latency: the result is valid in the cycle after the input transaction.
// throughput: one transaction per cycle; the debouncers and sequencer update in
// a single registered pass, and the result register lets a new tick in while
// the last result is taken in the same cycle.
// when the receiver stalls, the result register holds and in_ready drops until
// the result is taken.
// reset (rst_n low at a clock edge) loads the default tick counts and starts a
// retract pulse. configuration writes via cfg_we/cfg_index/cfg_data are registered,
// and a new value is used at the next reload of the count that uses it.
module press_cycle_controller #(
  parameter int DIP_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pcc_pkg::pcc_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pcc_pkg::pcc_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pcc_pkg::*;

  localparam logic [DIP_W-1:0] DipMask =
    (DIP_BITS >= DIP_W) ? {DIP_W{1'b1}} : DIP_W'((1 << DIP_BITS) - 1);

  logic [CNT_W-1:0]   press_ticks_r, release_ticks_r;
  logic [TICK_W-1:0]  pulse_ticks_r, tenth_ticks_r;

  logic               up_state_r, up_state_nxt;
  logic               down_state_r, down_state_nxt;
  logic [CNT_W-1:0]   up_cnt_r, up_cnt_nxt;
  logic [CNT_W-1:0]   down_cnt_r, down_cnt_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [TICK_W-1:0]  pulse_left_r, pulse_left_nxt;
  logic [DWELL_W-1:0] dwell_left_r, dwell_left_nxt;
  logic [TICK_W-1:0]  unit_left_r, unit_left_nxt;

  logic               out_valid_r;
  pcc_out_t           out_data_r, out_data_nxt;

  logic               in_fire;
  logic [DIP_W-1:0]   dip;
  logic [DWELL_W-1:0] units;
  logic [DWELL_W-1:0] dwell_dec;
  logic [CNT_W-1:0]   up_dec, down_dec;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign dip   = in_data.dip_setting & DipMask;
  // dip * 10, at most 2550 so it fits the dwell counter
  assign units = {1'b0, dip, 3'b000} + {3'b000, dip, 1'b0};
  assign dwell_dec = dwell_left_r - DWELL_W'(1);
  assign up_dec    = up_cnt_r - CNT_W'(1);
  assign down_dec  = down_cnt_r - CNT_W'(1);

  // debouncers
  always_comb begin
    up_state_nxt = up_state_r;
    if (in_data.up_raw == up_state_r) begin
      up_cnt_nxt = up_state_r ? release_ticks_r : press_ticks_r;
    end else if (up_dec == '0) begin
      up_state_nxt = in_data.up_raw;
      up_cnt_nxt   = in_data.up_raw ? release_ticks_r : press_ticks_r;
    end else begin
      up_cnt_nxt = up_dec;
    end

    down_state_nxt = down_state_r;
    if (in_data.down_raw == down_state_r) begin
      down_cnt_nxt = down_state_r ? release_ticks_r : press_ticks_r;
    end else if (down_dec == '0) begin
      down_state_nxt = in_data.down_raw;
      down_cnt_nxt   = in_data.down_raw ? release_ticks_r : press_ticks_r;
    end else begin
      down_cnt_nxt = down_dec;
    end
  end

  // sequencer
  always_comb begin
    phase_nxt      = phase_r;
    pulse_left_nxt = pulse_left_r;
    dwell_left_nxt = dwell_left_r;
    unit_left_nxt  = unit_left_r;
    case (phase_r)
      PH_IDLE: begin
        if (up_state_nxt) begin
          phase_nxt      = PH_RETRACT;
          pulse_left_nxt = pulse_ticks_r;
        end else if (down_state_nxt) begin
          dwell_left_nxt = units;
          phase_nxt      = PH_EXTEND;
          pulse_left_nxt = pulse_ticks_r;
        end
      end
      PH_EXTEND: begin
        if (pulse_left_r <= TICK_W'(1)) begin
          if (dwell_left_r == '0) begin
            phase_nxt      = PH_RETRACT;
            pulse_left_nxt = pulse_ticks_r;
          end else begin
            phase_nxt     = PH_DWELL;
            unit_left_nxt = tenth_ticks_r;
          end
        end else begin
          pulse_left_nxt = pulse_left_r - TICK_W'(1);
        end
      end
      PH_DWELL: begin
        if (unit_left_r <= TICK_W'(1)) begin
          unit_left_nxt = tenth_ticks_r;
          if (dwell_dec == '0 || up_state_nxt) begin
            dwell_left_nxt = '0;
            phase_nxt      = PH_RETRACT;
            pulse_left_nxt = pulse_ticks_r;
          end else begin
            dwell_left_nxt = dwell_dec;
          end
        end else begin
          unit_left_nxt = unit_left_r - TICK_W'(1);
        end
      end
      default: begin
        if (pulse_left_r <= TICK_W'(1)) begin
          phase_nxt = PH_IDLE;
        end else begin
          pulse_left_nxt = pulse_left_r - TICK_W'(1);
        end
      end
    endcase
  end

  always_comb begin
    out_data_nxt.extend_drive  = (phase_r == PH_EXTEND);
    out_data_nxt.retract_drive = (phase_r == PH_RETRACT);
    out_data_nxt.up_stable     = up_state_nxt;
    out_data_nxt.down_stable   = down_state_nxt;
    out_data_nxt.phase         = phase_r;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r   <= PRESS_TICKS_RST;
      release_ticks_r <= RELEASE_TICKS_RST;
      pulse_ticks_r   <= PULSE_TICKS_RST;
      tenth_ticks_r   <= TENTH_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRESS_TICKS:   press_ticks_r   <= cfg_data[CNT_W-1:0];
        CFG_RELEASE_TICKS: release_ticks_r <= cfg_data[CNT_W-1:0];
        CFG_PULSE_TICKS:   pulse_ticks_r   <= cfg_data[TICK_W-1:0];
        CFG_TENTH_TICKS:   tenth_ticks_r   <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_state_r   <= 1'b0;
      down_state_r <= 1'b0;
      up_cnt_r     <= RELEASE_TICKS_RST;
      down_cnt_r   <= RELEASE_TICKS_RST;
      phase_r      <= PH_RETRACT;
      pulse_left_r <= PULSE_TICKS_RST;
      dwell_left_r <= '0;
      unit_left_r  <= TENTH_TICKS_RST;
    end else if (in_fire) begin
      up_state_r   <= up_state_nxt;
      down_state_r <= down_state_nxt;
      up_cnt_r     <= up_cnt_nxt;
      down_cnt_r   <= down_cnt_nxt;
      phase_r      <= phase_nxt;
      pulse_left_r <= pulse_left_nxt;
      dwell_left_r <= dwell_left_nxt;
      unit_left_r  <= unit_left_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_one_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.extend_drive && out_data_r.retract_drive))
    else $error("extend and retract driven together");

  a_dwell_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DWELL) |-> (dwell_left_r != '0))
    else $error("dwell phase with no units left");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transaction gave no result");

  a_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(phase_r))
    else $error("phase moved without a transaction");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// testbench for the press cycle controller: switch debounce and extend/dwell/retract sequencing
module tb;
  import pcc_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DWELL_SCALE  = 10;
  localparam int DWELL_CAP    = (1 << DWELL_W) - 1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pcc_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pcc_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // register shadows and predicted sequencer state
  logic [CNT_W-1:0]   cfg_press, cfg_release;
  logic [TICK_W-1:0]  cfg_pulse, cfg_tenth;
  logic               up_lvl, down_lvl;
  logic [CNT_W-1:0]   up_cnt, down_cnt;
  logic [1:0]         cur_phase;
  logic [TICK_W-1:0]  pulse_cnt, unit_cnt;
  logic [DWELL_W-1:0] dwell_cnt;

  pcc_out_t due_outputs[$];
  int       error_count     = 0;
  int       ticks_sent      = 0;
  int       results_checked = 0;
  int       reg_loads       = 0;
  int       cycle_count     = 0;
  int       ready_hold      = 0;
  int       phase_seen[4]   = '{default: 0};
  bit       pace_gaps       = 1'b1;

  always #10 clk = ~clk;

  press_cycle_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  task automatic flag_error(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    if (!pace_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic debounce_step(input logic raw, inout logic lvl, inout logic [CNT_W-1:0] cnt);
    if (raw == lvl) begin
      cnt = lvl ? cfg_release : cfg_press;
    end else begin
      cnt = cnt - 1'b1;
      if (cnt == '0) begin
        lvl = raw;
        cnt = lvl ? cfg_release : cfg_press;
      end
    end
  endtask

  task automatic load_pulse(input logic [1:0] ph);
    cur_phase = ph;
    pulse_cnt = cfg_pulse;
  endtask

  function automatic bit pulse_done();
    if (pulse_cnt <= 1) return 1'b1;
    pulse_cnt = pulse_cnt - 1'b1;
    return 1'b0;
  endfunction

  task automatic predict_press_tick(input pcc_in_t t);
    logic [1:0] ph;
    int         units;
    pcc_out_t   r;
    ph = cur_phase;
    debounce_step(t.up_raw, up_lvl, up_cnt);
    debounce_step(t.down_raw, down_lvl, down_cnt);
    case (ph)
      PH_IDLE: begin
        if (up_lvl) begin
          load_pulse(PH_RETRACT);
        end else if (down_lvl) begin
          units = int'(t.dip_setting) * DWELL_SCALE;
          dwell_cnt = DWELL_W'((units > DWELL_CAP) ? DWELL_CAP : units);
          load_pulse(PH_EXTEND);
        end
      end
      PH_EXTEND: begin
        if (pulse_done()) begin
          if (dwell_cnt == '0) begin
            load_pulse(PH_RETRACT);
          end else begin
            cur_phase = PH_DWELL;
            unit_cnt = cfg_tenth;
          end
        end
      end
      PH_DWELL: begin
        if (unit_cnt <= 1) begin
          unit_cnt = cfg_tenth;
          dwell_cnt = dwell_cnt - 1'b1;
          if (dwell_cnt == '0 || up_lvl) begin
            dwell_cnt = '0;
            load_pulse(PH_RETRACT);
          end
        end else begin
          unit_cnt = unit_cnt - 1'b1;
        end
      end
      default: begin
        if (pulse_done()) cur_phase = PH_IDLE;
      end
    endcase
    r.extend_drive  = (ph == PH_EXTEND);
    r.retract_drive = (ph == PH_RETRACT);
    r.up_stable     = up_lvl;
    r.down_stable   = down_lvl;
    r.phase         = ph;
    due_outputs.push_back(r);
  endtask

  task automatic send_tick(input pcc_in_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    predict_press_tick(t);
    ticks_sent++;
  endtask

  task automatic hold(input logic up, input logic down, input logic [DIP_W-1:0] dip, input int n);
    pcc_in_t t;
    t.up_raw      = up;
    t.down_raw    = down;
    t.dip_setting = dip;
    repeat (n) send_tick(t);
  endtask

  // quiet switches until idle with both levels low; optionally press up to cut a dwell
  task automatic settle(input bit cut_dwell);
    while (cur_phase != PH_IDLE || up_lvl || down_lvl)
      hold(cut_dwell && cur_phase == PH_DWELL, 1'b0, DIP_W'($urandom_range(0, 255)), 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_outputs.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_PRESS_TICKS:   cfg_press   = value[CNT_W-1:0];
      CFG_RELEASE_TICKS: cfg_release = value[CNT_W-1:0];
      CFG_PULSE_TICKS:   cfg_pulse   = value[TICK_W-1:0];
      CFG_TENTH_TICKS:   cfg_tenth   = value[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [CNT_W-1:0] p_ticks, input logic [CNT_W-1:0] r_ticks,
                               input logic [TICK_W-1:0] pulse_len,
                               input logic [TICK_W-1:0] unit_len);
    logic [7:0] junk_a, junk_b;
    junk_a = 8'($urandom);
    junk_b = 8'($urandom);
    drain();
    // upper bits of the 8-bit registers carry junk that must be dropped
    write_reg(CFG_PRESS_TICKS, {junk_a, p_ticks});
    write_reg(CFG_RELEASE_TICKS, {junk_b, r_ticks});
    write_reg(CFG_PULSE_TICKS, pulse_len);
    write_reg(CFG_TENTH_TICKS, unit_len);
    cfg_we <= 1'b0;
    reg_loads++;
  endtask

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
      if (pace_gaps && $urandom_range(0, 3) == 0) ready_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    pcc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_outputs.size() == 0) begin
        flag_error("result transaction with nothing pending");
      end else begin
        want = due_outputs.pop_front();
        if (out_data.extend_drive !== want.extend_drive)
          flag_error($sformatf("result %0d extend_drive %b want %b", results_checked,
                               out_data.extend_drive, want.extend_drive));
        if (out_data.retract_drive !== want.retract_drive)
          flag_error($sformatf("result %0d retract_drive %b want %b", results_checked,
                               out_data.retract_drive, want.retract_drive));
        if (out_data.up_stable !== want.up_stable)
          flag_error($sformatf("result %0d up_stable %b want %b", results_checked,
                               out_data.up_stable, want.up_stable));
        if (out_data.down_stable !== want.down_stable)
          flag_error($sformatf("result %0d down_stable %b want %b", results_checked,
                               out_data.down_stable, want.down_stable));
        if (out_data.phase !== want.phase)
          flag_error($sformatf("result %0d phase %0d want %0d", results_checked,
                               out_data.phase, want.phase));
        phase_seen[want.phase]++;
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // default counts: switch activity inside the retract pulse that follows reset
  task automatic test_power_up();
    while (ticks_sent < 200)
      hold(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), DIP_W'($urandom_range(0, 255)),
           $urandom_range(5, 40));
    while (up_lvl || down_lvl)
      hold(1'b0, 1'b0, DIP_W'($urandom_range(0, 255)), 1);
  endtask

  task automatic test_wide_debounce();
    load_settings(8'hff, 8'hff, 16'd1, 16'd1);
    hold(1'b0, 1'b0, 8'd3, 1);
    // one tick short of the count, then the full count
    hold(1'b0, 1'b1, 8'd3, 254);
    hold(1'b0, 1'b0, 8'd3, 1);
    hold(1'b0, 1'b1, 8'd3, 255);
    // short counts take over at the next reload
    load_settings(8'd1, 8'd1, 16'd1, 16'd1);
    hold(1'b0, 1'b1, 8'd3, 1);
    hold(1'b0, 1'b0, 8'd3, 2);
  endtask

  task automatic test_zero_registers();
    load_settings(8'd0, 8'd0, 16'd0, 16'd0);
    hold(1'b0, 1'b1, 8'd1, 2);
    while (cur_phase == PH_RETRACT)
      hold(1'b0, 1'b1, 8'd1, 1);
    hold(1'b0, 1'b1, 8'd1, 40);
    // zero reload wraps the counter to 255 for both the press and the release
    hold(1'b1, 1'b0, 8'd0, 258);
    load_settings(8'd1, 8'd1, 16'd1, 16'd1);
    hold(1'b1, 1'b0, 8'd0, 1);
    settle(1'b0);
  endtask

  task automatic test_press_cycle();
    load_settings(8'd2, 8'd2, 16'd3, 16'd2);
    settle(1'b0);
    // zero dwell goes from extend straight to retract
    hold(1'b0, 1'b1, 8'd0, 3);
    settle(1'b0);
    // up while idle
    hold(1'b1, 1'b0, 8'hff, 3);
    settle(1'b0);
    // up ignored during extend, then cuts the dwell
    hold(1'b0, 1'b1, 8'd1, 3);
    hold(1'b1, 1'b0, 8'd1, 4);
    settle(1'b0);
    // full dwell, with new counts loaded while the extend pulse runs
    hold(1'b0, 1'b1, 8'd1, 3);
    load_settings(8'd3, 8'd1, 16'd5, 16'd3);
    settle(1'b0);
    // both switches at once: up wins
    hold(1'b1, 1'b1, 8'd2, 4);
    settle(1'b0);
    hold(1'b0, 1'b1, 8'hff, 4);
    settle(1'b1);
  endtask

  task automatic test_random_sessions();
    int               start, kind;
    logic [CNT_W-1:0] p, r;
    logic [DIP_W-1:0] dip;
    repeat (3) begin
      p = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(5, 12))
                                      : CNT_W'($urandom_range(1, 4));
      r = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(5, 12))
                                      : CNT_W'($urandom_range(1, 4));
      load_settings(p, r, TICK_W'($urandom_range(0, 8)), TICK_W'($urandom_range(0, 4)));
      pace_gaps = ($urandom_range(0, 3) != 0);
      start = ticks_sent;
      while (ticks_sent - start < 50) begin
        kind = $urandom_range(0, 9);
        dip = ($urandom_range(0, 4) == 0) ? DIP_W'($urandom_range(0, 255))
                                          : DIP_W'($urandom_range(0, 3));
        case (kind)
          0, 1, 2, 3: begin
            hold(1'b0, 1'b1, dip, p + $urandom_range(0, 6));
            hold(1'b0, 1'b0, dip, $urandom_range(0, r + 4));
          end
          4, 5: begin
            hold(1'b1, 1'b0, dip, p + $urandom_range(0, 6));
            hold(1'b0, 1'b0, dip, $urandom_range(0, r + 4));
          end
          6: hold(1'b0, 1'b0, dip, $urandom_range(1, 12));
          7: hold(1'b1, 1'b1, dip, p + $urandom_range(0, 4));
          default: begin
            repeat ($urandom_range(1, 10))
              hold(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   DIP_W'($urandom_range(0, 255)), 1);
          end
        endcase
      end
    end
    pace_gaps = 1'b1;
  endtask

  initial begin
    cfg_press   = PRESS_TICKS_RST;
    cfg_release = RELEASE_TICKS_RST;
    cfg_pulse   = PULSE_TICKS_RST;
    cfg_tenth   = TENTH_TICKS_RST;
    up_lvl      = 1'b0;
    down_lvl    = 1'b0;
    up_cnt      = cfg_release;
    down_cnt    = cfg_release;
    cur_phase   = PH_RETRACT;
    pulse_cnt   = cfg_pulse;
    dwell_cnt   = '0;
    unit_cnt    = cfg_tenth;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_power_up();
    test_wide_debounce();
    test_zero_registers();
    test_press_cycle();
    test_random_sessions();
    drain();
    repeat (4) @(posedge clk);
    if (due_outputs.size() != 0)
      flag_error($sformatf("%0d result transactions never arrived", due_outputs.size()));
    $display("summary: %0d ticks sent, %0d results checked, %0d register loads",
             ticks_sent, results_checked, reg_loads);
    $display("summary: ticks per phase idle %0d extend %0d dwell %0d retract %0d",
             phase_seen[0], phase_seen[1], phase_seen[2], phase_seen[3]);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
